>>> design/dsp_pkg.sv
// package for the dag shortest path unit: widths, constants, packed edge type
// no dependencies
package dsp_pkg;
    localparam int NODE_W = 6;
    localparam int WGT_W = 16;
    localparam int DIST_W = 32;
    localparam int CNT_W = 7;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;
    localparam logic signed [DIST_W-1:0] INF_MARK = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] NEG_MARK = 32'sh8000_0000;

    typedef struct packed {
        logic [NODE_W-1:0] from;
        logic [NODE_W-1:0] to;
        logic signed [WGT_W-1:0] weight;
    } edge_t;
endpackage

>>> design/dsp_if.sv
// valid/ready channel interfaces for edge requests and node results
// depends on dsp_pkg
interface dsp_edge_if;
    import dsp_pkg::*;
    logic valid;
    logic ready;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
    logic signed [WGT_W-1:0] edge_weight;
    logic last_edge;
    modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface dsp_node_if;
    import dsp_pkg::*;
    logic valid;
    logic ready;
    logic [NODE_W-1:0] node_index;
    logic signed [DIST_W-1:0] distance;
    logic reachable;
    logic last_node;
    modport source (output valid, node_index, distance, reachable, last_node, input ready);
    modport sink (input valid, node_index, distance, reachable, last_node, output ready);
endinterface

>>> design/dag_shortest_path_unit.sv
// dag shortest path unit: edge store, iterative dfs topological sort, relaxation
// after the last edge, the search scans the edge slots of each node on its stack, then
// relaxation scans all slots for each node; edges load one per cycle unless a result waits
// results leave one per cycle while the receiver is ready, node 0 first; not ready meanwhile
// reset (rst_n low, async) empties the edge store and sets node_count to 64
// depends on dsp_pkg and dsp_if
module dag_shortest_path_unit
    import dsp_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
)(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    dsp_edge_if.sink edge_in,
    dsp_node_if.source node_out
);
    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int SPW = $clog2(MAX_NODES + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_DFS_ROOT, S_DFS_RD, S_DFS_CHK, S_REL_PICK, S_REL_DU,
        S_REL_RD, S_REL_CHK, S_REL_ADD, S_REL_UPD, S_OUT
    } state_t;

    // memories
    edge_t edge_mem [MAX_EDGES];
    logic [NODE_W-1:0] topo_mem [MAX_NODES];
    logic [NODE_W-1:0] stk_node [MAX_NODES];
    logic [ECW-1:0] stk_pos [MAX_NODES];
    logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [MAX_NODES-1:0] visited_reg;
    // distance entries written in this run; others read as the infinity marker
    logic [MAX_NODES-1:0] dist_vld_reg;

    state_t state_reg;
    logic [CNT_W-1:0] node_count_reg;
    logic [ECW-1:0] edge_total_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] root_reg;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] fin_reg;
    logic [NODE_W-1:0] u_reg;
    logic [ECW-1:0] k_reg;
    logic signed [DIST_W-1:0] du_reg;
    logic signed [DIST_W-1:0] cand_reg;
    logic signed [DIST_W-1:0] dv_reg;
    logic [NODE_W-1:0] v_reg;
    edge_t e_reg;
    logic [CNT_W-1:0] oi_reg;
    logic ov_reg;
    logic [NODE_W-1:0] oidx_reg;
    logic signed [DIST_W-1:0] odist_reg;
    logic oreach_reg;
    logic olast_reg;

    logic [CNT_W-1:0] n_eff;
    logic signed [DIST_W:0] sum_w;
    logic signed [DIST_W-1:0] sat_w;
    logic [SPW-1:0] top_w;

    assign edge_in.ready = (state_reg == S_LOAD) && !ov_reg;
    assign node_out.valid = ov_reg;
    assign node_out.node_index = oidx_reg;
    assign node_out.distance = odist_reg;
    assign node_out.reachable = oreach_reg;
    assign node_out.last_node = olast_reg;

    // clamp configured node count
    always_comb
    begin
        if (node_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (node_count_reg > CNT_W'(MAX_NODES))
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = node_count_reg;
    end

    // saturating adder used by relaxation
    always_comb
    begin
        sum_w = {du_reg[DIST_W-1], du_reg} + (DIST_W+1)'(e_reg.weight);
        if (sum_w[DIST_W] != sum_w[DIST_W-1])
            sat_w = sum_w[DIST_W] ? NEG_MARK : INF_MARK;
        else
            sat_w = sum_w[DIST_W-1:0];
    end

    assign top_w = sp_reg - SPW'(1);

    // edge store write and edge read register in clocked logic
    always_ff @(posedge clk)
    begin
        if (edge_in.valid && edge_in.ready && edge_total_reg < ECW'(MAX_EDGES))
            edge_mem[edge_total_reg[EW-1:0]] <= {edge_in.edge_from, edge_in.edge_to,
                                                 edge_in.edge_weight};
        if (state_reg == S_DFS_RD || state_reg == S_REL_RD)
            e_reg <= edge_mem[k_reg[EW-1:0]];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            node_count_reg <= NODE_COUNT_RESET;
            edge_total_reg <= '0;
            visited_reg <= '0;
            dist_vld_reg <= '0;
            ov_reg <= 1'b0;
            n_reg <= '0;
            root_reg <= '0;
            sp_reg <= '0;
            fin_reg <= '0;
            k_reg <= '0;
            oi_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                node_count_reg <= cfg_wdata;
            // result register valid
            if (state_reg == S_OUT && (!ov_reg || node_out.ready))
                ov_reg <= 1'b1;
            else if (node_out.ready)
                ov_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (edge_in.valid && edge_in.ready)
                    begin
                        if (edge_total_reg < ECW'(MAX_EDGES))
                            edge_total_reg <= edge_total_reg + ECW'(1);
                        if (edge_in.last_edge)
                        begin
                            n_reg <= n_eff;
                            visited_reg <= '0;
                            dist_vld_reg <= '0;
                            root_reg <= '0;
                            fin_reg <= '0;
                            sp_reg <= '0;
                            state_reg <= S_DFS_ROOT;
                        end
                    end
                end
                // start a search from the next unvisited root, or begin relaxation when none is left
                S_DFS_ROOT:
                begin
                    if (root_reg >= n_reg)
                    begin
                        dist_mem[0] <= '0;
                        dist_vld_reg[0] <= 1'b1;
                        state_reg <= S_REL_PICK;
                    end
                    else
                    begin
                        if (!visited_reg[root_reg[NW-1:0]])
                        begin
                            visited_reg[root_reg[NW-1:0]] <= 1'b1;
                            stk_node[0] <= root_reg[NODE_W-1:0];
                            stk_pos[0] <= '0;
                            u_reg <= root_reg[NODE_W-1:0];
                            k_reg <= '0;
                            sp_reg <= SPW'(1);
                            state_reg <= S_DFS_RD;
                        end
                        root_reg <= root_reg + CNT_W'(1);
                    end
                end
                // read edge k of the top frame, or pop when exhausted
                S_DFS_RD:
                begin
                    if (k_reg >= edge_total_reg)
                    begin
                        if (fin_reg < SPW'(MAX_NODES))
                        begin
                            topo_mem[fin_reg[NW-1:0]] <= u_reg;
                            fin_reg <= fin_reg + SPW'(1);
                        end
                        sp_reg <= top_w;
                        if (top_w == '0)
                            state_reg <= S_DFS_ROOT;
                        else
                        begin
                            u_reg <= stk_node[top_w[NW-1:0] - NW'(1)];
                            k_reg <= stk_pos[top_w[NW-1:0] - NW'(1)];
                        end
                    end
                    else
                        state_reg <= S_DFS_CHK;
                end
                // a new frame's resume point is saved when it pushes a child
                S_DFS_CHK:
                begin
                    state_reg <= S_DFS_RD;
                    if (e_reg.from == u_reg && CNT_W'(e_reg.from) < n_reg
                        && CNT_W'(e_reg.to) < n_reg && !visited_reg[e_reg.to[NW-1:0]])
                    begin
                        stk_pos[top_w[NW-1:0]] <= k_reg + ECW'(1);
                        visited_reg[e_reg.to[NW-1:0]] <= 1'b1;
                        if (sp_reg < SPW'(MAX_NODES))
                        begin
                            stk_node[sp_reg[NW-1:0]] <= e_reg.to;
                            sp_reg <= sp_reg + SPW'(1);
                            u_reg <= e_reg.to;
                            k_reg <= '0;
                        end
                        else
                            k_reg <= k_reg + ECW'(1);
                    end
                    else
                        k_reg <= k_reg + ECW'(1);
                end
                // take nodes in reverse finishing order
                S_REL_PICK:
                begin
                    if (fin_reg == '0)
                    begin
                        oi_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        fin_reg <= fin_reg - SPW'(1);
                        u_reg <= topo_mem[fin_reg[NW-1:0] - NW'(1)];
                        k_reg <= '0;
                        state_reg <= S_REL_DU;
                    end
                end
                // fetch the distance of the picked node
                S_REL_DU:
                begin
                    du_reg <= dist_vld_reg[u_reg[NW-1:0]] ? dist_mem[u_reg[NW-1:0]]
                                                           : INF_MARK;
                    state_reg <= S_REL_RD;
                end
                S_REL_RD:
                begin
                    if (du_reg == INF_MARK || k_reg >= edge_total_reg)
                        state_reg <= S_REL_PICK;
                    else
                        state_reg <= S_REL_CHK;
                end
                S_REL_CHK:
                begin
                    v_reg <= e_reg.to;
                    dv_reg <= dist_vld_reg[e_reg.to[NW-1:0]] ? dist_mem[e_reg.to[NW-1:0]]
                                                              : INF_MARK;
                    if (e_reg.from == u_reg && CNT_W'(e_reg.to) < n_reg)
                        state_reg <= S_REL_ADD;
                    else
                    begin
                        k_reg <= k_reg + ECW'(1);
                        state_reg <= S_REL_RD;
                    end
                end
                S_REL_ADD:
                begin
                    cand_reg <= sat_w;
                    state_reg <= S_REL_UPD;
                end
                S_REL_UPD:
                begin
                    if (cand_reg < dv_reg)
                    begin
                        dist_mem[v_reg[NW-1:0]] <= cand_reg;
                        dist_vld_reg[v_reg[NW-1:0]] <= 1'b1;
                        if (v_reg == u_reg)
                            du_reg <= cand_reg;
                    end
                    k_reg <= k_reg + ECW'(1);
                    state_reg <= S_REL_RD;
                end
                // one result per node; written entries are always below the marker
                S_OUT:
                begin
                    if (!ov_reg || node_out.ready)
                    begin
                        oidx_reg <= oi_reg[NODE_W-1:0];
                        oreach_reg <= dist_vld_reg[oi_reg[NW-1:0]];
                        odist_reg <= dist_vld_reg[oi_reg[NW-1:0]]
                                     ? dist_mem[oi_reg[NW-1:0]] : -32'sd1;
                        olast_reg <= (oi_reg + CNT_W'(1)) == n_reg;
                        oi_reg <= oi_reg + CNT_W'(1);
                        if ((oi_reg + CNT_W'(1)) == n_reg)
                        begin
                            edge_total_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // checks
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(MAX_NODES)) else $error("stack overflow");
    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg <= SPW'(MAX_NODES)) else $error("finish order overflow");
    a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
        edge_in.ready |-> state_reg == S_LOAD) else $error("ready while busy");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECW'(MAX_EDGES)) else $error("edge count overflow");
endmodule

>>> tb/dag_shortest_path_unit_test.sv
// testbench for dag_shortest_path_unit: sends edge requests, predicts per-node distances
// depends on dsp_pkg, dsp_if and the unit itself
`timescale 1ns / 1ps

module dag_shortest_path_unit_test;
    import dsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [NODE_W-1:0] node_index;
        logic signed [DIST_W-1:0] distance;
        logic reachable;
        logic last_node;
    } dist_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    dsp_edge_if edge_ch();
    dsp_node_if node_ch();

    dag_shortest_path_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .edge_in(edge_ch.sink),
        .node_out(node_ch.source)
    );

    // predictor state
    edge_t graph_edges[DEF_MAX_EDGES];
    int unsigned graph_edge_count;
    int unsigned node_setting;
    dist_result_t pending_dists[$];

    // stimulus and checking state
    int send_idle_pct;
    int stall_pct;
    int hold_off_cycles;
    int error_count;
    int mismatch_count;
    int results_seen;
    int edges_sent;
    int graphs_sent;
    int idle_cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned nodes_in_use();
        if (node_setting == 0)
            return 1;
        if (node_setting > DEF_MAX_NODES)
            return DEF_MAX_NODES;
        return node_setting;
    endfunction

    function automatic logic signed [DIST_W-1:0] clamp_sum(logic signed [DIST_W-1:0] a,
                                                           logic signed [WGT_W-1:0] w);
        longint s;
        s = longint'(a) + longint'(w);
        if (s > longint'(INF_MARK))
            return INF_MARK;
        if (s < longint'(NEG_MARK))
            return NEG_MARK;
        return s[DIST_W-1:0];
    endfunction

    // topological order by iterative dfs, then relaxation; queues expected distances
    task automatic solve_graph();
        int unsigned n;
        int unsigned finish_count;
        int unsigned sp;
        bit seen[DEF_MAX_NODES];
        int unsigned order[DEF_MAX_NODES];
        int unsigned stk_node[DEF_MAX_NODES];
        int unsigned stk_pos[DEF_MAX_NODES];
        logic signed [DIST_W-1:0] node_dist[DEF_MAX_NODES];
        int unsigned u;
        int unsigned v;
        int unsigned k;
        bit pushed;
        logic signed [DIST_W-1:0] cand;
        dist_result_t r;
        n = nodes_in_use();
        finish_count = 0;
        for (int i = 0; i < DEF_MAX_NODES; i++)
        begin
            seen[i] = 0;
            node_dist[i] = INF_MARK;
        end
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            seen[root] = 1;
            stk_node[0] = root;
            stk_pos[0] = 0;
            sp = 1;
            while (sp > 0)
            begin
                u = stk_node[sp-1];
                pushed = 0;
                for (k = stk_pos[sp-1]; k < graph_edge_count; k++)
                begin
                    v = graph_edges[k].to;
                    if (graph_edges[k].from != u || graph_edges[k].from >= n || v >= n)
                        continue;
                    if (!seen[v])
                    begin
                        stk_pos[sp-1] = k + 1;
                        seen[v] = 1;
                        if (sp < DEF_MAX_NODES)
                        begin
                            stk_node[sp] = v;
                            stk_pos[sp] = 0;
                            sp++;
                        end
                        pushed = 1;
                        break;
                    end
                end
                if (!pushed)
                begin
                    sp--;
                    if (finish_count < DEF_MAX_NODES)
                    begin
                        order[finish_count] = u;
                        finish_count++;
                    end
                end
            end
        end
        // relax in reverse finishing order
        node_dist[0] = 0;
        while (finish_count > 0)
        begin
            finish_count--;
            u = order[finish_count];
            if (u >= n || node_dist[u] == INF_MARK)
                continue;
            for (k = 0; k < graph_edge_count; k++)
            begin
                v = graph_edges[k].to;
                if (graph_edges[k].from != u || v >= n)
                    continue;
                cand = clamp_sum(node_dist[u], graph_edges[k].weight);
                if (cand < node_dist[v])
                    node_dist[v] = cand;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.node_index = NODE_W'(i);
            r.reachable = (node_dist[i] != INF_MARK);
            r.distance = r.reachable ? node_dist[i] : -32'sd1;
            r.last_node = (i + 1 == n);
            pending_dists.insert(pending_dists.size(), r);
        end
        graph_edge_count = 0;
    endtask

    // send one edge request, then update the prediction; valid stays up for a follower
    task automatic send_edge(int unsigned from_node, int unsigned to_node, int wgt, bit last);
        edge_t e;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            edge_ch.valid <= 1'b0;
            @(posedge clk);
        end
        e.from = NODE_W'(from_node);
        e.to = NODE_W'(to_node);
        e.weight = WGT_W'(wgt);
        edge_ch.valid <= 1'b1;
        edge_ch.edge_from <= e.from;
        edge_ch.edge_to <= e.to;
        edge_ch.edge_weight <= e.weight;
        edge_ch.last_edge <= last;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
        edges_sent++;
        if (graph_edge_count < DEF_MAX_EDGES)
        begin
            graph_edges[graph_edge_count] = e;
            graph_edge_count++;
        end
        if (last)
        begin
            graphs_sent++;
            solve_graph();
        end
    endtask

    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        while (pending_dists.size() != 0)
            @(posedge clk);
    endtask

    // register write only while idle; extra cycles cover any trailing work
    task automatic write_node_count(int unsigned value);
        wait_drained();
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        node_setting = value;
    endtask

    task automatic set_idling(int s_pct, int r_pct);
        send_idle_pct = s_pct;
        stall_pct = r_pct;
    endtask

    // random graph of mostly forward edges with a few stray ones
    task automatic send_random_graph(int unsigned edge_num);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int w;
        n = nodes_in_use();
        for (int i = 0; i < edge_num; i++)
        begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            if ($urandom_range(9) < 8 && a > b)
            begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            if ($urandom_range(19) == 0)
                b = $urandom_range(63);
            case ($urandom_range(3))
                0: w = $urandom_range(200) - 100;
                1: w = $urandom_range(65535) - 32768;
                2: w = $urandom_range(1) ? 32767 : -32768;
                default: w = $urandom_range(1000);
            endcase
            send_edge(a, b, w, i == edge_num - 1);
        end
    endtask

    // directed: field extremes, chains, out-of-range endpoints, cycles and self loops
    task automatic test_directed();
        set_idling(0, 0);
        write_node_count(4);
        send_edge(0, 1, 32767, 0);
        send_edge(1, 2, -32768, 0);
        send_edge(2, 3, 5, 0);
        send_edge(63, 63, -1, 0);
        send_edge(0, 3, 100, 1);
        // cycle and self loop
        send_edge(1, 1, 3, 0);
        send_edge(0, 2, 7, 0);
        send_edge(2, 0, -9, 0);
        send_edge(2, 1, 21845, 0);
        send_edge(42, 21, -21846, 1);
        // lone edge, node 0 isolated
        send_edge(3, 2, 1, 1);
        // node count zero acts as one
        write_node_count(0);
        send_edge(0, 0, 10, 1);
        // above the maximum acts as the maximum
        write_node_count(127);
        send_edge(0, 63, -32768, 0);
        send_edge(63, 62, -32768, 1);
        write_node_count(1);
        send_edge(0, 0, 1, 1);
        // reset value of node_count was 64; restore
        write_node_count(64);
        send_edge(0, 32, 1000, 0);
        send_edge(32, 16, -500, 1);
    endtask

    // deepest chain of minimum weights, fills the search stack
    task automatic test_saturation();
        write_node_count(64);
        for (int i = 0; i < 63; i++)
            send_edge(i, i + 1, -32768, i == 62);
    endtask

    task automatic test_random_idling();
        write_node_count(8);
        set_idling(82, 0);
        repeat (3) send_random_graph($urandom_range(2, 4));
        write_node_count(2);
        set_idling(0, 82);
        repeat (3) send_random_graph($urandom_range(1, 2));
        write_node_count(16);
        set_idling(14, 14);
        repeat (3) send_random_graph($urandom_range(2, 5));
        set_idling(0, 0);
        repeat (2) send_random_graph($urandom_range(2, 4));
    endtask

    // receiver holds off while graphs keep coming, then sender pauses to drain
    task automatic test_back_pressure();
        write_node_count(6);
        set_idling(0, 0);
        hold_off_cycles = 3000;
        repeat (4) send_random_graph(3);
        wait_drained();
        send_random_graph(3);
        wait_drained();
    endtask

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_ch.ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            node_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            node_ch.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        dist_result_t want;
        if (rst_n && node_ch.valid && node_ch.ready)
        begin
            results_seen++;
            if (pending_dists.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: node %0d distance %0d",
                             node_ch.node_index, node_ch.distance);
            end
            else
            begin
                want = pending_dists.pop_front();
                if (node_ch.node_index !== want.node_index || node_ch.distance !== want.distance
                    || node_ch.reachable !== want.reachable
                    || node_ch.last_node !== want.last_node)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0d %0b %0b, got %0d %0d %0b %0b",
                                 want.node_index, want.distance, want.reachable, want.last_node,
                                 node_ch.node_index, node_ch.distance, node_ch.reachable,
                                 node_ch.last_node);
                end
            end
        end
    end

    // watchdog over cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((edge_ch.valid && edge_ch.ready) || (node_ch.valid && node_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        edge_ch.valid = 1'b0;
        edge_ch.edge_from = '0;
        edge_ch.edge_to = '0;
        edge_ch.edge_weight = '0;
        edge_ch.last_edge = 1'b0;
        node_setting = NODE_COUNT_RESET;
        graph_edge_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        mismatch_count = 0;
        results_seen = 0;
        edges_sent = 0;
        graphs_sent = 0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // first graph runs under the reset node count
        send_edge(0, 5, 7, 1);
        test_directed();
        test_saturation();
        test_random_idling();
        test_back_pressure();
        wait_drained();
        repeat (100) @(posedge clk);
        $display("covered %0d edges in %0d graphs, %0d node distances checked",
                 edges_sent, graphs_sent, results_seen);
        $display("node counts 0 to 127, weight extremes, cycles, stray endpoints, back pressure");
        if (error_count == 0 && pending_dists.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
